// ----- src/b64_pkg.sv -----
`default_nettype none

package b64_pkg;

    // Job queue between the front and back ends
    localparam int JOB_FIFO_DEPTH = 4;
    localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);

    // Pad character
    localparam logic [7:0] PAD_CHAR = 8'h3d;

    // Result counts per job
    localparam logic [2:0] ENC_FULL_CHARS  = 3'd4;
    localparam logic [2:0] DEC_FULL_BYTES  = 3'd3;

    // One unit of output work: a left-aligned 24-bit group and how to expand it
    typedef struct packed {
        logic [23:0] bits;    // group value, left-aligned
        logic        enc;     // 1: emit four characters, 0: emit bytes
        logic [2:0]  n_data;  // characters from the alphabet / bytes; 0 is the end marker
        logic        last;    // flag the final result of this job as message end
    } job_t;

    // Alphabet lookup: six-bit value to ASCII
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return 8'h2b;
        else
            return 8'h2f;
    endfunction

    // Reverse lookup: {valid, six-bit value}; invalid for '=' and any non-alphabet code
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
            return {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7a)
            return {1'b1, 6'(c - 8'h47)};
        else if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 6'(c + 8'h04)};
        else if (c == 8'h2b)
            return {1'b1, 6'd62};
        else if (c == 8'h2f)
            return {1'b1, 6'd63};
        else
            return 7'd0;
    endfunction

endpackage

`default_nettype wire

// ----- src/b64_if.sv -----
`default_nettype none

// Input channel: one byte or character per transaction
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Output channel: one character or byte per transaction
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_data;
    logic       out_last;

    modport source (output valid, output out_byte, output out_has_data, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_data, input out_last,
                    output ready);
endinterface

`default_nettype wire

// ----- src/b64_front.sv -----
`default_nettype none

module b64_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         job_full,
    output logic              job_push,
    output b64_pkg::job_t     job_data
);

    logic        mode_reg, mode_next;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  fill_reg, fill_next;
    logic        stop_reg, stop_next;

    logic        accept;
    logic [23:0] enc_sh;
    logic [23:0] dec_sh;
    logic [6:0]  dec_v;
    logic [23:0] dec_bits;
    logic [1:0]  dec_fill;
    logic        dec_full;

    assign in_ready = !job_full;
    assign accept   = in_valid && in_ready;
    assign enc_sh   = {bits_reg[15:0], in_byte};
    assign dec_v    = b64_pkg::dec_char(in_byte);
    assign dec_sh   = {bits_reg[17:0], dec_v[5:0]};

    // Classify the transaction, update the group and build a job
    always_comb
    begin
        mode_next = mode_reg;
        bits_next = bits_reg;
        fill_next = fill_reg;
        stop_next = stop_reg;
        job_push  = 1'b0;
        job_data  = '0;
        dec_bits  = bits_reg;
        dec_fill  = fill_reg;
        dec_full  = 1'b0;

        if (cfg_we)
        begin
            mode_next = cfg_wdata;
            bits_next = '0;
            fill_next = '0;
            stop_next = 1'b0;
        end
        else if (accept)
        begin
            if (!mode_reg)
            begin
                // Encode: gather three bytes
                job_data.enc = 1'b1;
                if (fill_reg == 2'd2)
                begin
                    job_push         = 1'b1;
                    job_data.bits    = enc_sh;
                    job_data.n_data  = b64_pkg::ENC_FULL_CHARS;
                    job_data.last    = in_last;
                    bits_next        = '0;
                    fill_next        = '0;
                end
                else
                begin
                    bits_next = enc_sh;
                    fill_next = fill_reg + 2'd1;
                    if (in_last)
                    begin
                        job_push      = 1'b1;
                        job_data.last = 1'b1;
                        if (fill_reg == 2'd1)
                        begin
                            job_data.bits   = {enc_sh[15:0], 8'h00};
                            job_data.n_data = 3'd3;
                        end
                        else
                        begin
                            job_data.bits   = {enc_sh[7:0], 16'h0000};
                            job_data.n_data = 3'd2;
                        end
                    end
                end
            end
            else
            begin
                // Decode: gather four characters until a stop
                job_data.enc = 1'b0;
                if (!stop_reg)
                begin
                    if (!dec_v[6])
                    begin
                        stop_next = 1'b1;
                    end
                    else if (fill_reg == 2'd3)
                    begin
                        dec_full        = 1'b1;
                        job_push        = 1'b1;
                        job_data.bits   = dec_sh;
                        job_data.n_data = b64_pkg::DEC_FULL_BYTES;
                        job_data.last   = in_last;
                        dec_bits        = '0;
                        dec_fill        = '0;
                    end
                    else
                    begin
                        dec_bits = dec_sh;
                        dec_fill = fill_reg + 2'd1;
                    end
                end
                bits_next = dec_bits;
                fill_next = dec_fill;

                // Flush a partial group at message end
                if (in_last && !dec_full)
                begin
                    job_push      = 1'b1;
                    job_data.last = 1'b1;
                    if (dec_fill == 2'd2)
                    begin
                        job_data.bits   = {dec_bits[11:0], 12'h000};
                        job_data.n_data = 3'd1;
                    end
                    else if (dec_fill == 2'd3)
                    begin
                        job_data.bits   = {dec_bits[17:0], 6'h00};
                        job_data.n_data = 3'd2;
                    end
                    else
                    begin
                        job_data.n_data = 3'd0;
                    end
                end
            end

            // Message end clears the group
            if (in_last)
            begin
                bits_next = '0;
                fill_next = '0;
                stop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            bits_reg <= '0;
            fill_reg <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            stop_reg <= stop_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/b64_job_fifo.sv -----
`default_nettype none

module b64_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire b64_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output b64_pkg::job_t      head_data
);

    b64_pkg::job_t                slot_reg [b64_pkg::JOB_FIFO_DEPTH];
    logic [b64_pkg::JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b64_pkg::JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b64_pkg::JOB_PTR_W:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == (b64_pkg::JOB_PTR_W+1)'(b64_pkg::JOB_FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (b64_pkg::JOB_PTR_W)'(do_push);
        rd_ptr_next = rd_ptr_reg + (b64_pkg::JOB_PTR_W)'(do_pop);
        count_next  = count_reg + (b64_pkg::JOB_PTR_W+1)'(do_push)
                                - (b64_pkg::JOB_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- src/b64_back.sv -----
`default_nettype none

module b64_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire b64_pkg::job_t job_data,
    output logic               job_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_has_data,
    output logic               out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;

    logic       load;
    logic [1:0] final_idx;
    logic [5:0] sextet;
    logic [7:0] octet;

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_has_data = has_reg;
    assign out_last     = last_reg;

    assign load    = job_valid && (!valid_reg || out_ready);
    assign job_pop = load && (idx_reg == final_idx);

    // Index of the final result of the head job
    always_comb
    begin
        if (job_data.enc)
            final_idx = 2'd3;
        else if (job_data.n_data == 3'd0)
            final_idx = 2'd0;
        else
            final_idx = 2'(job_data.n_data - 3'd1);
    end

    // Pick the field for the current result
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = job_data.bits[23:18];
            2'd1:    sextet = job_data.bits[17:12];
            2'd2:    sextet = job_data.bits[11:6];
            default: sextet = job_data.bits[5:0];
        endcase
        case (idx_reg)
            2'd0:    octet = job_data.bits[23:16];
            2'd1:    octet = job_data.bits[15:8];
            default: octet = job_data.bits[7:0];
        endcase
    end

    // Expand the head job one result per transaction
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        has_next   = has_reg;
        last_next  = last_reg;

        if (load)
        begin
            valid_next = 1'b1;
            last_next  = job_data.last && (idx_reg == final_idx);
            if (job_data.enc)
            begin
                has_next = 1'b1;
                if ({1'b0, idx_reg} < job_data.n_data)
                    byte_next = b64_pkg::enc_char(sextet);
                else
                    byte_next = b64_pkg::PAD_CHAR;
            end
            else if (job_data.n_data == 3'd0)
            begin
                has_next  = 1'b0;
                byte_next = 8'h00;
            end
            else
            begin
                has_next  = 1'b1;
                byte_next = octet;
            end
            idx_next = (idx_reg == final_idx) ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ----- src/base64_codec_top.sv -----
`default_nettype none

// Streaming Base64 codec (standard alphabet, '=' padding). cfg_we/cfg_wdata sets the
// mode (0 encode, 1 decode) and clears any partial group; write it only while idle.
// Input transactions carry one byte with a message-end flag; output transactions carry
// one character or byte, a data flag (0 only on the empty end marker of a decoded
// message) and a message-end flag. The front end takes one input per cycle while the job
// queue is not full and hands each finished group to a four-entry job queue; the back
// end emits one result per cycle from that queue through a registered output while the
// receiver is ready. Encoding throughput is therefore set by the single-result back end,
// which gives four results per three input bytes; decoding takes one character per cycle.
module base64_codec_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    b64_in_if.sink    in_ch,
    b64_out_if.source out_ch
);

    logic          job_full;
    logic          job_push;
    b64_pkg::job_t job_wdata;
    logic          job_pop;
    logic          job_valid;
    b64_pkg::job_t job_head;

    // Classify input and collect groups
    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_byte   (in_ch.in_byte),
        .in_last   (in_ch.in_last),
        .job_full  (job_full),
        .job_push  (job_push),
        .job_data  (job_wdata)
    );

    // Decouple front and back ends
    b64_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_wdata),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_data  (job_head)
    );

    // Expand jobs into output transactions
    b64_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_data     (job_head),
        .job_pop      (job_pop),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_byte     (out_ch.out_byte),
        .out_has_data (out_ch.out_has_data),
        .out_last     (out_ch.out_last)
    );

endmodule

`default_nettype wire

// ----- bench/base64_codec_top_tb.sv -----
`default_nettype none

module base64_codec_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_ENCODE   = 1'b0;
    localparam logic MODE_DECODE   = 1'b1;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   RANDOM_PHASES = 8;
    localparam int   PHASE_ITEMS   = 18;
    localparam int   REPORT_QUIET  = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } codec_result_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    b64_in_if  in_ch ();
    b64_out_if out_ch ();

    base64_codec_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the codec state
    logic        mode_decode;
    logic [23:0] grp_bits;
    int          grp_fill;
    logic        dec_stopped;

    codec_result_t due_results [$];
    logic [7:0]    msg_buf [$];

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    int items_sent    = 0;
    int msgs_ended    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;

    always #10 clk = ~clk;

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    // Six-bit value of a character, -1 for the pad and anything outside the alphabet
    function automatic int sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == "+")
            return 62;
        if (c == "/")
            return 63;
        return -1;
    endfunction

    function automatic void clear_group();
        grp_bits    = '0;
        grp_fill    = 0;
        dec_stopped = 1'b0;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic h, input logic l);
        codec_result_t r;
        r.data      = d;
        r.has_data  = h;
        r.last      = l;
        due_results = {due_results, r};
    endfunction

    function automatic void add_msg_byte(input logic [7:0] b);
        msg_buf = {msg_buf, b};
    endfunction

    // Work out the results one accepted input transaction causes
    function automatic void predict_item(input logic [7:0] b, input logic last);
        int          produced;
        int          v;
        int          cnt;
        logic [23:0] val;
        produced = 0;
        if (!mode_decode)
        begin
            grp_bits = {grp_bits[15:0], b};
            grp_fill++;
            if (grp_fill == 3)
            begin
                for (int s = 0; s < 4; s++)
                    push_result(alphabet_char(grp_bits[23 - 6 * s -: 6]), 1'b1,
                                last && s == 3);
                grp_bits = '0;
                grp_fill = 0;
            end
            else if (last)
            begin
                // Zero-fill the partial group and pad out to four characters
                val = grp_bits << (8 * (3 - grp_fill));
                for (int s = 0; s < 4; s++)
                    push_result((s <= grp_fill) ? alphabet_char(val[23 - 6 * s -: 6])
                                                : b64_pkg::PAD_CHAR, 1'b1, s == 3);
            end
        end
        else
        begin
            if (!dec_stopped)
            begin
                v = sextet_of(b);
                // The pad or a stray character halts decoding until message end
                if (v < 0)
                    dec_stopped = 1'b1;
                else
                begin
                    grp_bits = {grp_bits[17:0], 6'(v)};
                    if (grp_fill == 3)
                    begin
                        for (int s = 0; s < 3; s++)
                            push_result(grp_bits[23 - 8 * s -: 8], 1'b1, last && s == 2);
                        produced = 3;
                        grp_bits = '0;
                        grp_fill = 0;
                    end
                    else
                        grp_fill++;
                end
            end
            // Flush a partial group at message end, or mark an empty end
            if (last && produced == 0)
            begin
                if (grp_fill >= 2)
                begin
                    val = grp_bits << (6 * (4 - grp_fill));
                    cnt = grp_fill - 1;
                    for (int s = 0; s < cnt; s++)
                        push_result(val[23 - 8 * s -: 8], 1'b1, s + 1 == cnt);
                end
                else
                    push_result(8'h00, 1'b0, 1'b1);
            end
        end
        if (last)
            clear_group();
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < REPORT_QUIET)
            $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Drive receiver back-pressure
    always @(negedge clk)
        out_ch.ready = ($urandom_range(99) >= snk_stall_pct);

    // Compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        codec_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (due_results.size() == 0)
                report_mismatch("unexpected result, out_byte", out_ch.out_byte, 8'h00);
            else
            begin
                want = due_results.pop_front();
                if (out_ch.out_byte !== want.data)
                    report_mismatch("out_byte", out_ch.out_byte, want.data);
                if (out_ch.out_has_data !== want.has_data)
                    report_mismatch("out_has_data", 8'(out_ch.out_has_data),
                                    8'(want.has_data));
                if (out_ch.out_last !== want.last)
                    report_mismatch("out_last", 8'(out_ch.out_last), 8'(want.last));
            end
        end
    end

    // Abort if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, due_results.size());
            $display("base64_codec_top_tb NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until the codec takes it
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.in_last = last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_item(b, last);
        items_sent++;
        if (last)
            msgs_ended++;
        @(negedge clk);
    endtask

    task automatic send_buffered(input int budget);
        for (int i = 0; i < msg_buf.size() && i < budget; i++)
            send_item(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        msg_buf.delete();
        for (int i = 0; i < s.len(); i++)
            add_msg_byte(s[i]);
        send_buffered(s.len());
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle_idle();
        in_ch.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(posedge clk);
        mode_decode = m;
        clear_group();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic build_encode_msg();
        msg_buf.delete();
        repeat ($urandom_range(1, 7))
            add_msg_byte(8'($urandom_range(255)));
    endtask

    // Mostly well-formed text with random content, the rest noise
    task automatic build_decode_msg();
        int k;
        msg_buf.delete();
        if ($urandom_range(99) < 70)
        begin
            k = $urandom_range(1, 9);
            repeat (k)
                add_msg_byte(alphabet_char(6'($urandom_range(63))));
            if (k % 4 == 2 && $urandom_range(99) < 60)
            begin
                add_msg_byte(b64_pkg::PAD_CHAR);
                add_msg_byte(b64_pkg::PAD_CHAR);
            end
            else if (k % 4 == 3 && $urandom_range(99) < 60)
                add_msg_byte(b64_pkg::PAD_CHAR);
            if ($urandom_range(99) < 20)
                add_msg_byte(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                if ($urandom_range(1))
                    add_msg_byte(alphabet_char(6'($urandom_range(63))));
                else
                    add_msg_byte(8'($urandom_range(255)));
        end
    endtask

    // Encode extremes: partial groups of one and two bytes, full group at message end
    task automatic test_encode_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_mode(MODE_ENCODE);
        msg_buf = '{8'h00, 8'hFF, 8'h80, 8'h01};
        send_buffered(msg_buf.size());
        msg_buf = '{8'hFF, 8'hFF};
        send_buffered(msg_buf.size());
        msg_buf = '{8'h3C, 8'h0F, 8'hC3};
        send_buffered(msg_buf.size());
        settle_idle();
    endtask

    // Decode: full group, stop on stray character and pad, lone character, empty end
    task automatic test_decode_directed();
        src_idle_pct  = 19;
        snk_stall_pct = 19;
        write_mode(MODE_DECODE);
        send_text("TWFu");
        send_text("TQ!");
        send_text("T");
        send_text("QUJ=X");
        send_text("z09+/");
        settle_idle();
    endtask

    // Random messages over every idling pattern in both modes; a phase may end
    // mid-message so the mode write also has to discard a partial group
    task automatic test_random_traffic();
        int budget;
        int sent;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ((p / 2) % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            write_mode((p % 2) ? MODE_DECODE : MODE_ENCODE);
            budget = PHASE_ITEMS;
            while (budget > 0)
            begin
                if (mode_decode)
                    build_decode_msg();
                else
                    build_encode_msg();
                sent = (msg_buf.size() < budget) ? msg_buf.size() : budget;
                send_buffered(budget);
                budget -= sent;
            end
            settle_idle();
        end
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        mode_decode   = MODE_ENCODE;
        clear_group();

        // Hold reset, then release it on a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_encode_directed();
        test_decode_directed();
        test_random_traffic();
        settle_idle();

        $display("covered %0d input items in %0d messages, %0d results checked",
                 items_sent, msgs_ended, results_seen);
        $display("both modes under free flow, sender gaps, receiver stalls and both");
        if (err_count == 0)
            $display("base64_codec_top_tb OK");
        else
            $display("base64_codec_top_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
